// File: src/mqf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue FIFO package
// Shared constants, codes and controller-to-datapath command type.
// ----------------------------------------------------------------------------
package mqf_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int QUEUE_COUNT_DEF = 4;
	localparam int WORD_WIDTH_DEF  = 32;
	localparam int LOST_W          = 32;
	localparam int QIDX_W          = 3;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_LIMIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} mqf_cmd_t;

endpackage

// File: src/mqf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mqf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/mqf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue FIFO controller
// Sequences accept, execute and result cycles for each item.
// ----------------------------------------------------------------------------
module mqf_ctrl
	import mqf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output mqf_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   capture;

	assign busy    = (state_q == S_EXEC);
	assign capture = start && !busy;

	assign cmd.capture = capture;
	assign cmd.execute = (state_q == S_EXEC);
	assign done        = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			unique case (state_q)
				S_IDLE:  state_q <= capture ? S_EXEC : S_IDLE;
				S_EXEC:  state_q <= S_FETCH;
				S_FETCH: state_q <= capture ? S_EXEC : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> busy)
		else $error("accepted item did not enter execute");
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("execute not followed by result strobe");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without execute");
`endif

endmodule

// File: src/mqf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue FIFO datapath
// Item registers, per-queue pointers and counters, slot RAM and result regs.
// ----------------------------------------------------------------------------
module mqf_datapath
	import mqf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
	parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mqf_cmd_t              cmd,
	input  logic [1:0]            op,
	input  logic [QIDX_W-1:0]     queue_index,
	input  logic [WORD_WIDTH-1:0] write_data,
	output logic [1:0]            status,
	output logic [WORD_WIDTH-1:0] read_data,
	output logic [LOST_W-1:0]     lost_count
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int SLOTS = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [1:0]            op_q;
	logic [QIDX_W-1:0]     qidx_q;
	logic [WORD_WIDTH-1:0] wdata_q;

	logic [PW-1:0]     wp_q   [QUEUE_COUNT];
	logic [PW-1:0]     rp_q   [QUEUE_COUNT];
	logic [PW-1:0]     occ_q  [QUEUE_COUNT];
	logic [LOST_W-1:0] lost_q [QUEUE_COUNT];

	logic [1:0]        status_q;
	logic [LOST_W-1:0] lost_out_q;
	logic              rd_sel_q;

	logic              in_range;
	logic [QW-1:0]     q;
	logic [PW-1:0]     cur_wp, cur_rp, cur_occ, nxt_wp, nxt_rp;
	logic [LOST_W-1:0] cur_lost, sat_lost;
	logic              full, empty;
	logic              do_push, do_pop, do_drop, do_clear;
	logic [1:0]        res_status;
	logic [LOST_W-1:0] res_lost;
	logic [AW-1:0]     waddr, raddr;
	logic [WORD_WIDTH-1:0] ram_rdata;

	assign in_range = (32'(qidx_q) < QUEUE_COUNT);
	assign q        = QW'(qidx_q);
	assign cur_wp   = wp_q[q];
	assign cur_rp   = rp_q[q];
	assign cur_occ  = occ_q[q];
	assign cur_lost = lost_q[q];
	assign full     = (cur_occ == PW'(QUEUE_DEPTH - 1));
	assign empty    = (cur_occ == '0);
	assign nxt_wp   = (cur_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
	assign nxt_rp   = (cur_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
	assign sat_lost = (cur_lost == '1) ? cur_lost : cur_lost + 1'b1;

	assign waddr = AW'(int'(q) * QUEUE_DEPTH + int'(cur_wp));
	assign raddr = AW'(int'(q) * QUEUE_DEPTH + int'(cur_rp));

	always_comb begin
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_drop    = 1'b0;
		do_clear   = 1'b0;
		res_status = ST_OK;
		res_lost   = cur_lost;
		if (!in_range) begin
			res_status = ST_LIMIT;
			res_lost   = '0;
		end else begin
			unique case (op_t'(op_q))
				OP_CLEAR: begin
					do_clear = 1'b1;
					res_lost = '0;
				end
				OP_PUSH: begin
					if (full) begin
						do_drop    = 1'b1;
						res_status = ST_FULL;
						res_lost   = sat_lost;
					end else begin
						do_push = 1'b1;
					end
				end
				OP_POP: begin
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						do_pop = 1'b1;
					end
				end
				default: res_status = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			qidx_q  <= queue_index;
			wdata_q <= write_data;
		end
		if (cmd.execute) begin
			status_q   <= res_status;
			lost_out_q <= res_lost;
			rd_sel_q   <= do_pop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				wp_q[i]   <= '0;
				rp_q[i]   <= '0;
				occ_q[i]  <= '0;
				lost_q[i] <= '0;
			end
		end else if (cmd.execute) begin
			if (do_clear) begin
				wp_q[q]   <= '0;
				rp_q[q]   <= '0;
				occ_q[q]  <= '0;
				lost_q[q] <= '0;
			end
			if (do_push) begin
				wp_q[q]  <= nxt_wp;
				occ_q[q] <= cur_occ + 1'b1;
			end
			if (do_pop) begin
				rp_q[q]  <= nxt_rp;
				occ_q[q] <= cur_occ - 1'b1;
			end
			if (do_drop) begin
				lost_q[q] <= sat_lost;
			end
		end
	end

	mqf_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(SLOTS),
		.AW   (AW)
	) u_slots (
		.clk  (clk),
		.we   (cmd.execute && do_push),
		.waddr(waddr),
		.wdata(wdata_q),
		.re   (cmd.execute && do_pop),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	assign status     = status_q;
	assign lost_count = lost_out_q;
	assign read_data  = rd_sel_q ? ram_rdata : '0;

endmodule

// File: src/multi_queue_fifo_engine.sv
`timescale 1ns / 1ps
// Result: the strobe (done) is registered from the execute state, as are status and read data.
// Accept: a new item is taken in idle or fetch but not while busy; busy is high in the execute
// cycle after acceptance, and the registered read of the slot RAM completes in the fetch state.
// Reset: arst_n clears pointers, occupancy, lost counters and control; slot RAM is not cleared.
// The receiver cannot stall; each result strobe (done) is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Multi-queue FIFO engine
// Independent circular word queues with clear, push and pop commands.
// ----------------------------------------------------------------------------
module multi_queue_fifo_engine
	import mqf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
	parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [QIDX_W-1:0]     queue_index,
	input  logic [WORD_WIDTH-1:0] write_data,
	output logic                  done,
	output logic [1:0]            status,
	output logic [WORD_WIDTH-1:0] read_data,
	output logic [LOST_W-1:0]     lost_count
);

	mqf_cmd_t cmd;

	mqf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	mqf_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.QUEUE_COUNT(QUEUE_COUNT),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (op),
		.queue_index(queue_index),
		.write_data (write_data),
		.status     (status),
		.read_data  (read_data),
		.lost_count (lost_count)
	);

endmodule
